/* src/tps_pkg.sv */
// Shared types and constants for the triangle/plane segment pipeline.
`default_nettype none
package tps_pkg;

  // Long-division pipeline: one quotient bit per stage
  localparam int DIV_STAGES = 34;
  localparam int FRONT_STAGES = 2;
  localparam int BACK_STAGES = 3;
  localparam int NUM_STAGES = FRONT_STAGES + DIV_STAGES + BACK_STAGES;
  localparam int NUM_LANES = 4;

  typedef struct packed {
    logic signed [31:0] vert_a_x;
    logic signed [31:0] vert_a_y;
    logic signed [31:0] vert_a_z;
    logic signed [31:0] vert_b_x;
    logic signed [31:0] vert_b_y;
    logic signed [31:0] vert_b_z;
    logic signed [31:0] vert_c_x;
    logic signed [31:0] vert_c_y;
    logic signed [31:0] vert_c_z;
    logic signed [31:0] facet_normal_x;
    logic signed [31:0] facet_normal_y;
    logic signed [31:0] plane_height;
  } tri_in_t;

  typedef struct packed {
    logic               segment_valid;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } seg_out_t;

  // Per-triangle data that rides alongside the dividers
  typedef struct packed {
    logic               seg_ok;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
  } tag_t;

  // Per-lane data that rides inside a divider
  typedef struct packed {
    logic signed [31:0] p;
    logic               neg;
  } side_t;

  typedef struct packed {
    logic signed [31:0] p;
    logic signed [32:0] dv;
    logic signed [32:0] nm;
    logic signed [32:0] dn;
  } lerp_raw_t;

  typedef struct packed {
    logic [65:0] num;
    logic [32:0] den;
    side_t       side;
  } div_in_t;

  typedef struct packed {
    logic [33:0] quo;
    side_t       side;
  } div_out_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic [32:0] r;
    r = v[32] ? (33'd0 - v) : v;
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/tps_in_if.sv */
// Triangle input channel.
`default_nettype none
interface tps_in_if;
  logic             valid;
  logic             ready;
  tps_pkg::tri_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/tps_out_if.sv */
// Segment output channel.
`default_nettype none
interface tps_out_if;
  logic              valid;
  logic              ready;
  tps_pkg::seg_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/tps_front.sv */
// Edge crossing test, edge selection, differences and magnitude products.
`default_nettype none
module tps_front (
  input  wire logic                                  clk,
  input  wire logic [tps_pkg::FRONT_STAGES-1:0]      en,
  input  wire tps_pkg::tri_in_t                      in_data,
  output tps_pkg::div_in_t [tps_pkg::NUM_LANES-1:0]  lanes,
  output tps_pkg::tag_t                              tag
);

  tps_pkg::lerp_raw_t [tps_pkg::NUM_LANES-1:0] raw;
  tps_pkg::lerp_raw_t [tps_pkg::NUM_LANES-1:0] raw_next;
  tps_pkg::tag_t tag0;
  tps_pkg::tag_t tag0_next;

  logic signed [31:0] vx [3];
  logic signed [31:0] vy [3];
  logic signed [31:0] vz [3];
  logic [2:0] below;
  logic c_ab, c_ac, c_bc;
  logic [1:0] e1_p, e1_q, e2_p, e2_q;

  // Stage 0: crossing test, pick the two crossing edges, form differences
  always_comb begin
    logic [1:0] pi, qi;
    logic signed [31:0] pc, qc;
    vx[0] = in_data.vert_a_x; vy[0] = in_data.vert_a_y; vz[0] = in_data.vert_a_z;
    vx[1] = in_data.vert_b_x; vy[1] = in_data.vert_b_y; vz[1] = in_data.vert_b_z;
    vx[2] = in_data.vert_c_x; vy[2] = in_data.vert_c_y; vz[2] = in_data.vert_c_z;
    for (int k = 0; k < 3; k++) begin
      below[k] = vz[k] < in_data.plane_height;
    end
    c_ab = below[0] ^ below[1];
    c_ac = below[0] ^ below[2];
    c_bc = below[1] ^ below[2];
    // first crossing edge: a-b, else a-c; second: b-c, else a-c
    e1_p = 2'd0;
    e1_q = c_ab ? 2'd1 : 2'd2;
    e2_p = c_bc ? 2'd1 : 2'd0;
    e2_q = 2'd2;
    tag0_next.seg_ok = (c_ab & c_ac & ~c_bc) | (c_ab & ~c_ac & c_bc) | (~c_ab & c_ac & c_bc);
    tag0_next.nx = in_data.facet_normal_x;
    tag0_next.ny = in_data.facet_normal_y;
    for (int l = 0; l < tps_pkg::NUM_LANES; l++) begin
      pi = (l < 2) ? e1_p : e2_p;
      qi = (l < 2) ? e1_q : e2_q;
      pc = l[0] ? vy[pi] : vx[pi];
      qc = l[0] ? vy[qi] : vx[qi];
      raw_next[l].p  = pc;
      raw_next[l].dv = 33'(qc) - 33'(pc);
      raw_next[l].nm = 33'(in_data.plane_height) - 33'(vz[pi]);
      raw_next[l].dn = 33'(vz[qi]) - 33'(vz[pi]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      raw  <= raw_next;
      tag0 <= tag0_next;
    end
  end

  // Stage 1: magnitudes, quotient sign, |dv| * |num|
  always_ff @(posedge clk) begin
    if (en[1]) begin
      tag <= tag0;
      for (int l = 0; l < tps_pkg::NUM_LANES; l++) begin
        lanes[l].num      <= 66'(tps_pkg::mag33(raw[l].dv)) * 66'(tps_pkg::mag33(raw[l].nm));
        lanes[l].den      <= tps_pkg::mag33(raw[l].dn);
        lanes[l].side.p   <= raw[l].p;
        lanes[l].side.neg <= raw[l].dv[32] ^ raw[l].nm[32] ^ raw[l].dn[32];
      end
    end
  end

endmodule
`default_nettype wire

/* src/tps_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module tps_div (
  input  wire logic                               clk,
  input  wire logic [tps_pkg::DIV_STAGES-1:0]     en,
  input  wire tps_pkg::div_in_t                   din,
  output tps_pkg::div_out_t                       dout
);

  localparam int K = tps_pkg::DIV_STAGES;

  logic [31:0]           rem  [K];
  logic [33:0]           low  [K];
  logic [33:0]           quo  [K];
  logic [32:0]           den  [K];
  tps_pkg::side_t        side [K];

  logic [31:0]           rem_next  [K];
  logic [33:0]           low_next  [K];
  logic [33:0]           quo_next  [K];

  for (genvar k = 0; k < K; k++) begin : g_stage
    logic [31:0] rem_in;
    logic [33:0] low_in;
    logic [33:0] quo_in;
    logic [32:0] den_in;
    tps_pkg::side_t side_in;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    // dividend high word seeds the remainder; quotient fits in K bits
    if (k == 0) begin : g_first
      assign rem_in  = din.num[65:34];
      assign low_in  = din.num[33:0];
      assign quo_in  = '0;
      assign den_in  = din.den;
      assign side_in = din.side;
    end else begin : g_rest
      assign rem_in  = rem[k-1];
      assign low_in  = low[k-1];
      assign quo_in  = quo[k-1];
      assign den_in  = den[k-1];
      assign side_in = side[k-1];
    end

    // compare-subtract step
    always_comb begin
      trial = {rem_in, low_in[33]};
      diff  = trial - den_in;
      ge    = trial >= den_in;
      rem_next[k] = ge ? diff[31:0] : trial[31:0];
      low_next[k] = {low_in[32:0], 1'b0};
      quo_next[k] = {quo_in[32:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]  <= rem_next[k];
        low[k]  <= low_next[k];
        quo[k]  <= quo_next[k];
        den[k]  <= den_in;
        side[k] <= side_in;
      end
    end
  end

  assign dout.quo  = quo[K-1];
  assign dout.side = side[K-1];

endmodule
`default_nettype wire

/* src/tps_back.sv */
// Crossing points, orientation products and endpoint ordering.
`default_nettype none
module tps_back (
  input  wire logic                                   clk,
  input  wire logic [tps_pkg::BACK_STAGES-1:0]        en,
  input  wire tps_pkg::div_out_t [tps_pkg::NUM_LANES-1:0] lanes,
  input  wire tps_pkg::tag_t                          tag_in,
  output tps_pkg::seg_out_t                           seg
);

  logic signed [31:0] pt   [tps_pkg::NUM_LANES];
  logic signed [31:0] pt_next [tps_pkg::NUM_LANES];
  tps_pkg::tag_t      tag_a;
  logic               ok_b;
  logic signed [31:0] pt_b [tps_pkg::NUM_LANES];
  logic signed [64:0] cross_a;
  logic signed [64:0] cross_b;

  // Stage A: point = p +/- quotient, clamped to 32 bits
  always_comb begin
    logic signed [35:0] pe, qe, r;
    for (int l = 0; l < tps_pkg::NUM_LANES; l++) begin
      pe = 36'(lanes[l].side.p);
      qe = $signed({2'b00, lanes[l].quo});
      r  = lanes[l].side.neg ? (pe - qe) : (pe + qe);
      if (r > 36'sh0_7FFF_FFFF) begin
        pt_next[l] = 32'sh7FFF_FFFF;
      end else if (r < -36'sh0_8000_0000) begin
        pt_next[l] = -32'sh8000_0000;
      end else begin
        pt_next[l] = r[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tag_a <= tag_in;
      for (int l = 0; l < tps_pkg::NUM_LANES; l++) begin
        pt[l] <= pt_next[l];
      end
    end
  end

  // Stage B: dx * ny and dy * nx
  always_ff @(posedge clk) begin
    logic signed [32:0] dx, dy;
    dx = 33'(pt[2]) - 33'(pt[0]);
    dy = 33'(pt[3]) - 33'(pt[1]);
    if (en[1]) begin
      ok_b    <= tag_a.seg_ok;
      cross_a <= dx * 65'(tag_a.ny);
      cross_b <= dy * 65'(tag_a.nx);
      for (int l = 0; l < tps_pkg::NUM_LANES; l++) begin
        pt_b[l] <= pt[l];
      end
    end
  end

  // Stage C: keep order when the cross z is positive, else swap
  always_ff @(posedge clk) begin
    logic keep;
    keep = cross_a > cross_b;
    if (en[2]) begin
      if (!ok_b) begin
        seg <= '0;
      end else begin
        seg.segment_valid <= 1'b1;
        seg.start_x <= keep ? pt_b[0] : pt_b[2];
        seg.start_y <= keep ? pt_b[1] : pt_b[3];
        seg.end_x   <= keep ? pt_b[2] : pt_b[0];
        seg.end_y   <= keep ? pt_b[3] : pt_b[1];
      end
    end
  end

endmodule
`default_nettype wire

/* src/triangle_plane_segment.sv */
// Top level: triangle / slicing plane segment pipeline.
// Path from input beat to output beat: 2 front, 34 divider, 3 back stages.
// Throughput: one triangle per cycle while the output is not stalled; the one-bit-per-stage dividers set the depth.
// A stalled output holds its beat while empty stages upstream keep filling.
// Synchronous reset clears all stage valid bits; payload registers are not reset.
`default_nettype none
module triangle_plane_segment (
  input  wire logic  clk,
  input  wire logic  rst,
  tps_in_if.sink     tri_in,
  tps_out_if.source  seg_out
);

  localparam int NS = tps_pkg::NUM_STAGES;
  localparam int FS = tps_pkg::FRONT_STAGES;
  localparam int DS = tps_pkg::DIV_STAGES;

  logic [NS-1:0] valid;
  logic [NS:0]   en;

  tps_pkg::div_in_t  [tps_pkg::NUM_LANES-1:0] div_in;
  tps_pkg::div_out_t [tps_pkg::NUM_LANES-1:0] div_out;
  tps_pkg::tag_t front_tag;
  tps_pkg::tag_t tag_line [DS];

  // A stage loads when it is empty or its contents move on
  always_comb begin
    en[NS] = seg_out.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = ~valid[i] | en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= tri_in.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign tri_in.ready  = en[0];
  assign seg_out.valid = valid[NS-1];

  tps_front u_front (
    .clk     (clk),
    .en      (en[FS-1:0]),
    .in_data (tri_in.data),
    .lanes   (div_in),
    .tag     (front_tag)
  );

  for (genvar l = 0; l < tps_pkg::NUM_LANES; l++) begin : g_lane
    tps_div u_div (
      .clk  (clk),
      .en   (en[FS+DS-1:FS]),
      .din  (div_in[l]),
      .dout (div_out[l])
    );
  end

  // Normal and segment flag ride beside the dividers
  always_ff @(posedge clk) begin
    if (en[FS]) begin
      tag_line[0] <= front_tag;
    end
    for (int k = 1; k < DS; k++) begin
      if (en[FS+k]) begin
        tag_line[k] <= tag_line[k-1];
      end
    end
  end

  tps_back u_back (
    .clk    (clk),
    .en     (en[NS-1:FS+DS]),
    .lanes  (div_out),
    .tag_in (tag_line[DS-1]),
    .seg    (seg_out.data)
  );

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Testbench for the triangle / slicing plane segment pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int RANDOM_ITEMS = 650;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 2 * tps_pkg::NUM_STAGES;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = -32'sh7fffffff - 1;
  localparam logic signed [31:0] ONE     = 32'sh00010000;

  typedef struct {
    tps_pkg::tri_in_t  tri_beat;
    bit                typed;
    tps_pkg::seg_out_t seg;
  } stim_row_t;

  logic clk;
  logic rst;

  tps_in_if  tri_in ();
  tps_out_if seg_out ();

  triangle_plane_segment dut (
    .clk     (clk),
    .rst     (rst),
    .tri_in  (tri_in.sink),
    .seg_out (seg_out.source)
  );

  tps_pkg::seg_out_t seg_expq[$];
  stim_row_t stim_rows[$];
  int        errors;
  int        seg_seen;
  int        seg_valid_seen;
  int        idle_cycles;
  int        out_hold;
  bit        out_calm;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    return v[33] ? (34'd0 - v) : v;
  endfunction

  // Crossing point of edge p->q at height h, truncated toward p, clamped
  function automatic logic signed [31:0] cross_point(input logic signed [31:0] p,
      input logic signed [31:0] q, input logic signed [31:0] pz,
      input logic signed [31:0] qz, input logic signed [31:0] h);
    logic signed [33:0] dv, nm, dn;
    logic [79:0] prod, quo;
    logic signed [81:0] r;
    logic neg;
    dv = q - p;
    nm = h - pz;
    dn = qz - pz;
    if (dn == 0 || dv == 0 || nm == 0) return p;
    neg = (dv < 0) ^ (nm < 0) ^ (dn < 0);
    prod = 80'(mag34(dv)) * 80'(mag34(nm));
    quo = prod / 80'(mag34(dn));
    r = p;
    if (neg) r = r - $signed({2'b00, quo});
    else r = r + $signed({2'b00, quo});
    if (r > 82'(S32_MAX)) r = 82'(S32_MAX);
    if (r < 82'(S32_MIN)) r = 82'(S32_MIN);
    return r[31:0];
  endfunction

  // Expected segment for one triangle
  function automatic tps_pkg::seg_out_t slice_segment(input tps_pkg::tri_in_t t);
    logic signed [31:0] vx[3], vy[3], vz[3];
    logic signed [31:0] px[2], py[2];
    logic signed [33:0] dx, dy;
    logic signed [71:0] lhs, rhs;
    int ea[3], eb[3];
    int hits;
    tps_pkg::seg_out_t s;
    ea = '{0, 0, 1};
    eb = '{1, 2, 2};
    vx = '{t.vert_a_x, t.vert_b_x, t.vert_c_x};
    vy = '{t.vert_a_y, t.vert_b_y, t.vert_c_y};
    vz = '{t.vert_a_z, t.vert_b_z, t.vert_c_z};
    px = '{0, 0};
    py = '{0, 0};
    hits = 0;
    for (int e = 0; e < 3; e++) begin
      if ((vz[ea[e]] < t.plane_height) != (vz[eb[e]] < t.plane_height)) begin
        if (hits < 2) begin
          px[hits] = cross_point(vx[ea[e]], vx[eb[e]], vz[ea[e]], vz[eb[e]],
                                 t.plane_height);
          py[hits] = cross_point(vy[ea[e]], vy[eb[e]], vz[ea[e]], vz[eb[e]],
                                 t.plane_height);
        end
        hits++;
      end
    end
    s = '0;
    if (hits == 2) begin
      dx = px[1] - px[0];
      dy = py[1] - py[0];
      lhs = dx * t.facet_normal_y;
      rhs = dy * t.facet_normal_x;
      s.segment_valid = 1'b1;
      if (lhs > rhs) begin
        s.start_x = px[0]; s.start_y = py[0]; s.end_x = px[1]; s.end_y = py[1];
      end else begin
        s.start_x = px[1]; s.start_y = py[1]; s.end_x = px[0]; s.end_y = py[0];
      end
    end
    return s;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return ONE;
      default: return $urandom;
    endcase
  endfunction

  // Random triangle: mostly near-plane geometry, some full range, some extremes
  function automatic tps_pkg::tri_in_t rand_triangle();
    tps_pkg::tri_in_t t;
    int sel, span;
    logic signed [31:0] lo, hi;
    sel = $urandom_range(0, 99);
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (sel < 70) begin
      span = 1 << $urandom_range(4, 30);
      t.vert_a_x = $signed($urandom % span) - span / 2;
      t.vert_a_y = $signed($urandom % span) - span / 2;
      t.vert_a_z = $signed($urandom % span) - span / 2;
      t.vert_b_x = $signed($urandom % span) - span / 2;
      t.vert_b_y = $signed($urandom % span) - span / 2;
      t.vert_b_z = $signed($urandom % span) - span / 2;
      t.vert_c_x = $signed($urandom % span) - span / 2;
      t.vert_c_y = $signed($urandom % span) - span / 2;
      t.vert_c_z = $signed($urandom % span) - span / 2;
      lo = t.vert_a_z; hi = t.vert_a_z;
      if (t.vert_b_z < lo) lo = t.vert_b_z;
      if (t.vert_c_z < lo) lo = t.vert_c_z;
      if (t.vert_b_z > hi) hi = t.vert_b_z;
      if (t.vert_c_z > hi) hi = t.vert_c_z;
      case ($urandom_range(0, 9))
        0: t.plane_height = t.vert_b_z;
        1: t.plane_height = $signed($urandom % span) - span / 2;
        default: t.plane_height = lo + $signed(($urandom % (hi - lo + 1)));
      endcase
      if ($urandom_range(0, 9) == 0) t.facet_normal_x = 0;
      if ($urandom_range(0, 9) == 0) t.facet_normal_y = 0;
    end else if (sel >= 85) begin
      t.vert_a_x = pick_extreme(); t.vert_a_y = pick_extreme();
      t.vert_a_z = pick_extreme(); t.vert_b_x = pick_extreme();
      t.vert_b_y = pick_extreme(); t.vert_b_z = pick_extreme();
      t.vert_c_x = pick_extreme(); t.vert_c_y = pick_extreme();
      t.vert_c_z = pick_extreme(); t.facet_normal_x = pick_extreme();
      t.facet_normal_y = pick_extreme(); t.plane_height = pick_extreme();
    end
    return t;
  endfunction

  task automatic add_row(input tps_pkg::tri_in_t t, input bit typed,
                         input tps_pkg::seg_out_t s);
    stim_row_t r;
    r.tri_beat = t;
    r.typed = typed;
    r.seg = s;
    stim_rows.push_back(r);
  endtask

  // Directed rows
  task automatic build_table();
    tps_pkg::tri_in_t t;
    tps_pkg::seg_out_t none;
    none = '0;
    t = '0;
    add_row(t, 1'b1, none);
    t = '{default: S32_MIN};
    add_row(t, 1'b1, none);
    t = '{default: S32_MAX};
    t.plane_height = S32_MIN;
    add_row(t, 1'b1, none);
    t = '{default: S32_MIN};
    t.plane_height = S32_MAX;
    add_row(t, 1'b1, none);
    // unit triangle cut at z = 1, normal +y keeps edge order
    t = '0;
    t.vert_b_x = 2 * ONE;
    t.vert_c_y = 2 * ONE;
    t.vert_c_z = 2 * ONE;
    t.facet_normal_y = ONE;
    t.plane_height = ONE;
    add_row(t, 1'b1, '{1'b1, 32'sd0, ONE, ONE, ONE});
    // same cut, normal -y swaps
    t.facet_normal_y = -ONE;
    add_row(t, 1'b1, '{1'b1, ONE, ONE, 32'sd0, ONE});
    // zero normal swaps
    t.facet_normal_y = 0;
    add_row(t, 1'b1, '{1'b1, ONE, ONE, 32'sd0, ONE});
    // vertex on the plane counts as not below
    t.plane_height = 0;
    add_row(t, 1'b1, none);
    t.plane_height = 2 * ONE;
    add_row(t, 1'b0, none);
    // extreme edges and normals
    t = '{S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX,
          S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 32'sd0};
    add_row(t, 1'b0, none);
    t = '{S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN,
          S32_MIN, S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MAX};
    add_row(t, 1'b0, none);
    t = '{S32_MIN, S32_MAX, -32'sd1, S32_MAX, S32_MIN, 32'sd0,
          32'sd0, 32'sd0, S32_MIN, S32_MIN, S32_MIN, 32'sd0};
    add_row(t, 1'b0, none);
    t = '{32'sd5, -32'sd7, -32'sd1, -32'sd9, 32'sd3, 32'sd1,
          32'sd1, 32'sd1, 32'sd3, 32'sd1, -32'sd1, 32'sd0};
    add_row(t, 1'b0, none);
    for (int i = 0; i < 8; i++) add_row(rand_triangle(), 1'b0, none);
  endtask

  // Drive one triangle beat and wait for it to be taken
  task automatic send_triangle(input tps_pkg::tri_in_t t, input bit typed,
                               input tps_pkg::seg_out_t s);
    int gap;
    gap = 0;
    if ($urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      tri_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tri_in.valid = 1'b1;
    tri_in.data = t;
    do @(posedge clk); while (!tri_in.ready);
    seg_expq.push_back(typed ? s : slice_segment(t));
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    tps_pkg::seg_out_t none;
    none = '0;
    errors = 0;
    tri_in.valid = 1'b0;
    tri_in.data = '0;
    build_table();
    @(negedge rst);
    @(negedge clk);
    foreach (stim_rows[i]) send_triangle(stim_rows[i].tri_beat, stim_rows[i].typed,
                                         stim_rows[i].seg);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        tri_in.valid = 1'b0;
        while (seg_expq.size() != 0) @(negedge clk);
      end
      send_triangle(rand_triangle(), 1'b0, none);
    end
    tri_in.valid = 1'b0;
    while (seg_expq.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d triangles, %0d segments returned, %0d of them valid",
             stim_rows.size() + RANDOM_ITEMS, seg_seen, seg_valid_seen);
    $display("directed extremes, plane-on-vertex, swap cases, then random geometry");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Output backpressure, with calm stretches of no stalls
  initial begin
    seg_out.ready = 1'b0;
    out_hold = 0;
    out_calm = 1'b0;
  end

  always @(negedge clk) begin
    if (rst) begin
      seg_out.ready = 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) out_calm = ~out_calm;
      if (out_hold > 0) begin
        out_hold--;
        seg_out.ready = 1'b0;
      end else begin
        seg_out.ready = 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0)
          out_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 3);
      end
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d actual %0d", $realtime, name, want, got);
    end
  endtask

  // Compare each output beat with the oldest expectation
  always @(posedge clk) begin
    tps_pkg::seg_out_t want;
    if (!rst && seg_out.valid && seg_out.ready) begin
      seg_seen++;
      if (seg_out.data.segment_valid) seg_valid_seen++;
      if (seg_expq.size() == 0) begin
        errors++;
        $display("%0t: unexpected segment beat: expected none actual %p",
                 $realtime, seg_out.data);
      end else begin
        want = seg_expq.pop_front();
        check_field("segment_valid", want.segment_valid, seg_out.data.segment_valid);
        check_field("start_x", want.start_x, seg_out.data.start_x);
        check_field("start_y", want.start_y, seg_out.data.start_y);
        check_field("end_x", want.end_x, seg_out.data.end_x);
        check_field("end_y", want.end_y, seg_out.data.end_y);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (tri_in.valid && tri_in.ready) || (seg_out.valid && seg_out.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d segments pending", $realtime,
                 seg_expq.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    seg_seen = 0;
    seg_valid_seen = 0;
    idle_cycles = 0;
  end

endmodule
`default_nettype wire
